// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/shdp_pkg.sv =====
// ----------------------------------------------------------------------------
// shdp_pkg
// Sizes, codes and types of the double-hashed symbol table.
// ----------------------------------------------------------------------------
`default_nettype none

package shdp_pkg;

  localparam int unsigned TABLE_SLOTS = 1021;
  localparam int unsigned NAME_CHARS  = 8;
  localparam int unsigned STEP_MOD    = 31;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned NAME_W = 8 * NAME_CHARS;
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned STEP_W = $clog2(STEP_MOD + 1);
  // Shift-and-add over NAME_CHARS bytes stays below 2^(8 + NAME_CHARS).
  localparam int unsigned HASH_W = 8 + NAME_CHARS;

  // Reciprocals for the two constant remainders; the estimate is low by at
  // most one quotient step, so a single correction finishes the job.
  localparam int unsigned RECIP_W = HASH_W + 1;
  localparam int unsigned PROD_W  = HASH_W + RECIP_W;
  localparam int unsigned SHIFT_A = HASH_W + SLOT_W;
  localparam int unsigned SHIFT_B = HASH_W + STEP_W;
  localparam logic [RECIP_W-1:0] RECIP_A = RECIP_W'((64'd1 << SHIFT_A) / TABLE_SLOTS);
  localparam logic [RECIP_W-1:0] RECIP_B = RECIP_W'((64'd1 << SHIFT_B) / STEP_MOD);

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd2;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_MUL,
    FS_MOD,
    FS_SLOT_RD,
    FS_SLOT_CHK,
    FS_ENT_CHK,
    FS_DONE
  } fsm_e;

  typedef struct packed {
    logic              used;
    logic [SLOT_W-1:0] entry;
  } slot_t;

  typedef struct packed {
    logic              kind;
    logic [NAME_W-1:0] name;
  } entry_t;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [HASH_W-1:0] hash;
  } key_t;

endpackage

`default_nettype wire

// ===== sv/symbol_hash_table_double_probe_core.sv =====
// ----------------------------------------------------------------------------
// symbol_hash_table_double_probe_core
// Symbol table with double-hashed open addressing over a slot memory and an
// entry memory; lookup, lookup-or-insert and forced insert.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i/in_ready_o, action_i,         | request beat
//          | key_name_i, user_kind_i                  |
//  out     | out_valid_o/out_ready_i, status_o,       | result beat
//          | slot_index_o, entry_number_o             |
//
// One request at a time: hashing and remainders (FS_MUL, FS_MOD), then a slot read
// and check (FS_SLOT_RD, FS_SLOT_CHK) per probed slot plus FS_ENT_CHK for each name
// compare, then FS_DONE hands off the result. The probe loop runs through the single
// read port of the slot memory. After reset a clearing pass writes every slot before
// the first request beat is taken. A waiting result holds in the output register
// while the next request is already accepted.
`include "assert_macros.svh"
`default_nettype none

module symbol_hash_table_double_probe_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [shdp_pkg::KEY_W-1:0] key_name_i,
  input  logic                       user_kind_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [shdp_pkg::SLOT_W-1:0] slot_index_o,
  output logic [shdp_pkg::SLOT_W-1:0] entry_number_o
);
  import shdp_pkg::*;

  slot_t  slot_mem [TABLE_SLOTS];
  entry_t ent_mem  [TABLE_SLOTS];

  fsm_e              state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  logic [HASH_W-1:0] hash_q, hash_d;
  logic [NAME_W-1:0] name_q, name_d;
  logic              kind_q, kind_d;
  logic              lookup_q, lookup_d;
  logic              skip_q, skip_d;
  logic [HASH_W-1:0] qa_q, qa_d;
  logic [HASH_W-1:0] qb_q, qb_d;
  logic [SLOT_W-1:0] start_q, start_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] probes_q, probes_d;
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [SLOT_W-1:0] res_entry_q, res_entry_d;
  status_e           out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [SLOT_W-1:0] out_entry_q, out_entry_d;

  slot_t             slot_rd_q;
  entry_t            ent_rd_q;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  slot_t             slot_wdata;
  logic              ent_we;

  key_t              key_in;
  logic [PROD_W-1:0] prod_a, prod_b;
  logic [HASH_W-1:0] rem_a, rem_b;
  logic [STEP_W-1:0] rem_b_fix;
  logic [SLOT_W:0]   pos_sum;
  logic [SLOT_W-1:0] pos_next;
  logic              name_hit;

  // The name is cut at its first NUL; every later character reads as zero.
  function automatic key_t make_key(logic [KEY_W-1:0] raw);
    key_t       k;
    logic       alive;
    logic [7:0] c;
    k     = '0;
    alive = 1'b1;
    for (int i = 0; i < NAME_CHARS; i++) begin
      c = raw[8*i +: 8];
      if (c == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        k.name[8*i +: 8] = c;
        k.hash = (k.hash << 1) + HASH_W'(c);
      end
    end
    return k;
  endfunction

  assign key_in = make_key(key_name_i);

  assign prod_a = PROD_W'(hash_q) * PROD_W'(RECIP_A);
  assign prod_b = PROD_W'(hash_q) * PROD_W'(RECIP_B);
  assign rem_a  = hash_q - HASH_W'(qa_q * HASH_W'(TABLE_SLOTS));
  assign rem_b  = hash_q - HASH_W'(qb_q * HASH_W'(STEP_MOD));
  assign rem_b_fix = (rem_b >= HASH_W'(STEP_MOD)) ? STEP_W'(rem_b - HASH_W'(STEP_MOD))
                                                  : STEP_W'(rem_b);

  assign pos_sum  = (SLOT_W+1)'(pos_q) + (SLOT_W+1)'(step_q);
  assign pos_next = (pos_sum >= (SLOT_W+1)'(TABLE_SLOTS))
                  ? SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(pos_sum);

  assign name_hit = (ent_rd_q.name == name_q) && (ent_rd_q.kind == kind_q);

  assign in_ready_o     = (state_q == FS_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_index_o   = out_slot_q;
  assign entry_number_o = out_entry_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    hash_d       = hash_q;
    name_d       = name_q;
    kind_d       = kind_q;
    lookup_d     = lookup_q;
    skip_d       = skip_q;
    qa_d         = qa_q;
    qb_d         = qb_q;
    start_d      = start_q;
    step_d       = step_q;
    pos_d        = pos_q;
    probes_d     = probes_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_entry_d  = res_entry_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_entry_d  = out_entry_q;
    slot_we      = 1'b0;
    slot_waddr   = pos_q;
    slot_wdata   = '{used: 1'b1, entry: cnt_q};
    ent_we       = 1'b0;

    unique case (state_q)
      FS_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = FS_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      FS_IDLE: begin
        if (in_valid_i) begin
          hash_d   = key_in.hash;
          name_d   = key_in.name;
          kind_d   = user_kind_i;
          lookup_d = (action_i == ACT_LOOKUP);
          skip_d   = (action_i == ACT_INSERT);
          state_d  = FS_MUL;
        end
      end
      FS_MUL: begin
        qa_d    = HASH_W'(prod_a >> SHIFT_A);
        qb_d    = HASH_W'(prod_b >> SHIFT_B);
        state_d = FS_MOD;
      end
      FS_MOD: begin
        start_d  = (rem_a >= HASH_W'(TABLE_SLOTS)) ? SLOT_W'(rem_a - HASH_W'(TABLE_SLOTS))
                                                   : SLOT_W'(rem_a);
        step_d   = rem_b_fix + 1'b1;
        pos_d    = start_d;
        probes_d = '0;
        state_d  = FS_SLOT_RD;
      end
      FS_SLOT_RD: begin
        state_d = FS_SLOT_CHK;
      end
      FS_SLOT_CHK: begin
        if (!slot_rd_q.used) begin
          res_slot_d  = pos_q;
          res_entry_d = '0;
          state_d     = FS_DONE;
          if (lookup_q) begin
            res_status_d = ST_NOT_FOUND;
          end else if (cnt_q < SLOT_W'(TABLE_SLOTS - 1)) begin
            slot_we      = 1'b1;
            ent_we       = 1'b1;
            res_status_d = ST_INSERTED;
            res_entry_d  = cnt_q;
            cnt_d        = cnt_q + 1'b1;
          end else begin
            res_status_d = ST_FULL;
          end
        end else if (!skip_q) begin
          state_d = FS_ENT_CHK;
        end else if (probes_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          res_status_d = lookup_q ? ST_NOT_FOUND : ST_FULL;
          res_slot_d   = start_q;
          res_entry_d  = '0;
          state_d      = FS_DONE;
        end else begin
          pos_d    = pos_next;
          probes_d = probes_q + 1'b1;
          state_d  = FS_SLOT_RD;
        end
      end
      FS_ENT_CHK: begin
        if (name_hit) begin
          res_status_d = ST_FOUND;
          res_slot_d   = pos_q;
          res_entry_d  = slot_rd_q.entry;
          state_d      = FS_DONE;
        end else if (probes_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          res_status_d = lookup_q ? ST_NOT_FOUND : ST_FULL;
          res_slot_d   = start_q;
          res_entry_d  = '0;
          state_d      = FS_DONE;
        end else begin
          pos_d    = pos_next;
          probes_d = probes_q + 1'b1;
          state_d  = FS_SLOT_RD;
        end
      end
      FS_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_entry_d  = res_entry_q;
          state_d      = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q       <= hash_d;
    name_q       <= name_d;
    kind_q       <= kind_d;
    lookup_q     <= lookup_d;
    skip_q       <= skip_d;
    qa_q         <= qa_d;
    qb_q         <= qb_d;
    start_q      <= start_d;
    step_q       <= step_d;
    pos_q        <= pos_d;
    probes_q     <= probes_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_entry_q  <= res_entry_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_entry_q  <= out_entry_d;
  end

  // Slot memory: one write port, one registered read port at the probe slot.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[pos_q];
  end

  // Entry memory is read at the entry the probed slot points to.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[cnt_q] <= '{kind: kind_q, name: name_q};
    end
    ent_rd_q <= ent_mem[slot_rd_q.entry];
  end

  `ASSERT_NEXT(cnt_insert_a, state_q == FS_SLOT_CHK && ent_we,
               cnt_q == $past(cnt_q) + 1'b1 && state_q == FS_DONE,
               "fill count did not advance on insertion")
  `ASSERT_SAME(cnt_bound_a, state_q != FS_CLEAR, cnt_q <= SLOT_W'(TABLE_SLOTS - 1),
               "fill count beyond table capacity")
  `ASSERT_SAME(found_skip_a, state_q == FS_DONE && res_status_q == ST_FOUND, !skip_q,
               "forced insert reported a match")
  `ASSERT_SAME(pos_range_a, state_q == FS_SLOT_CHK || state_q == FS_ENT_CHK,
               pos_q < SLOT_W'(TABLE_SLOTS) && step_q != '0,
               "probe position or step out of range")
  `ASSERT_SAME(ent_write_a, ent_we, slot_we && !slot_rd_q.used && !lookup_q,
               "entry written without claiming an empty slot")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives name requests into the double-hashed symbol table and checks every
// result beat against a behavioral copy of the slot and entry tables.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import shdp_pkg::*;

  localparam logic [1:0] ACT_LOOKUP_OR_INSERT = 2'd1;
  localparam logic [1:0] ACT_SPARE            = 2'd3;
  localparam int unsigned MAX_REPORTS         = 10;

  typedef struct {
    logic [1:0]       act;
    logic [KEY_W-1:0] key;
    logic             kind;
  } sym_request_t;

  typedef struct {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] entry;
  } lookup_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        action;
  logic [KEY_W-1:0]  key_name;
  logic              user_kind;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_index;
  logic [SLOT_W-1:0] entry_number;

  symbol_hash_table_double_probe_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .key_name_i     (key_name),
    .user_kind_i    (user_kind),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .slot_index_o   (slot_index),
    .entry_number_o (entry_number)
  );

  // Behavioral copy of the table state.
  bit                slot_live      [TABLE_SLOTS];
  bit [SLOT_W-1:0]   slot_ent       [TABLE_SLOTS];
  bit [NAME_W-1:0]   entry_name_mem [TABLE_SLOTS];
  bit                entry_kind_mem [TABLE_SLOTS];
  int unsigned       insert_total;
  int unsigned       next_entry_id;

  sym_request_t      pending_requests[$];
  lookup_result_t    expected_results[$];
  logic [KEY_W-1:0]  key_pool[$];
  logic              kind_pool[$];

  int unsigned       requests_queued;
  int unsigned       results_seen;
  int unsigned       fail_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  bit                in_fire;

  function automatic lookup_result_t probe_symbol_table(logic [1:0] act_in,
                                                        logic [KEY_W-1:0] raw,
                                                        logic kind);
    logic [1:0]        act;
    logic [NAME_W-1:0] name;
    logic [7:0]        ch;
    int unsigned       hash;
    int unsigned       start;
    int unsigned       stride;
    int unsigned       pos;
    bit                cut;
    bit                hit_empty;
    lookup_result_t    res;
    act = (act_in == ACT_SPARE) ? ACT_LOOKUP_OR_INSERT : act_in;
    name = '0;
    hash = 0;
    cut = 1'b0;
    hit_empty = 1'b0;
    // Everything from the first NUL onward is dropped, both from the name
    // and from the hash.
    for (int i = 0; i < NAME_CHARS; i++) begin
      ch = raw[8*i +: 8];
      if (ch == 8'h00) cut = 1'b1;
      if (!cut) begin
        name[8*i +: 8] = ch;
        hash = (hash << 1) + ch;
      end
    end
    start = hash % TABLE_SLOTS;
    stride = hash % STEP_MOD + 1;
    pos = start;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slot_live[pos]) begin
        hit_empty = 1'b1;
        break;
      end
      if (act != ACT_INSERT && entry_name_mem[slot_ent[pos]] == name &&
          entry_kind_mem[slot_ent[pos]] == kind) begin
        res.status = ST_FOUND;
        res.slot = SLOT_W'(pos);
        res.entry = slot_ent[pos];
        return res;
      end
      pos = (pos + stride) % TABLE_SLOTS;
    end
    res.entry = '0;
    if (!hit_empty) begin
      res.status = (act == ACT_LOOKUP) ? ST_NOT_FOUND : ST_FULL;
      res.slot = SLOT_W'(start);
    end else if (act == ACT_LOOKUP) begin
      res.status = ST_NOT_FOUND;
      res.slot = SLOT_W'(pos);
    end else if (insert_total + 1 >= TABLE_SLOTS || next_entry_id >= TABLE_SLOTS) begin
      res.status = ST_FULL;
      res.slot = SLOT_W'(pos);
    end else begin
      entry_name_mem[next_entry_id] = name;
      entry_kind_mem[next_entry_id] = kind;
      slot_live[pos] = 1'b1;
      slot_ent[pos] = SLOT_W'(next_entry_id);
      insert_total++;
      res.status = ST_INSERTED;
      res.slot = SLOT_W'(pos);
      res.entry = SLOT_W'(next_entry_id);
      next_entry_id++;
    end
    return res;
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", what);
  endfunction

  // Random name of 0 to 8 nonzero characters, zero padded.
  function automatic logic [KEY_W-1:0] fresh_name();
    logic [KEY_W-1:0] key;
    int unsigned      len;
    key = '0;
    len = ($urandom_range(99) < 2) ? 0 : $urandom_range(1, NAME_CHARS);
    for (int i = 0; i < len; i++) key[8*i +: 8] = 8'($urandom_range(1, 255));
    return key;
  endfunction

  // Half the time, fills the bytes after the terminating NUL with junk.
  function automatic logic [KEY_W-1:0] add_tail(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] key;
    int               len;
    bit               junk;
    key = raw;
    len = NAME_CHARS;
    junk = $urandom_range(1);
    for (int i = NAME_CHARS - 1; i >= 0; i--) begin
      if (raw[8*i +: 8] == 8'h00) len = i;
    end
    for (int i = len + 1; i < NAME_CHARS; i++) begin
      key[8*i +: 8] = junk ? 8'($urandom_range(0, 255)) : 8'h00;
    end
    return key;
  endfunction

  task automatic push_request(logic [1:0] act, logic [KEY_W-1:0] key, logic kind);
    sym_request_t req;
    req.act = act;
    req.key = key;
    req.kind = kind;
    pending_requests.push_back(req);
    requests_queued++;
    if (act != ACT_LOOKUP) begin
      key_pool.push_back(key);
      kind_pool.push_back(kind);
    end
  endtask

  task automatic queue_directed();
    push_request(ACT_LOOKUP, '0, 1'b0);                     // empty table, empty name
    push_request(ACT_LOOKUP_OR_INSERT, '0, 1'b0);
    push_request(ACT_LOOKUP, '0, 1'b0);
    push_request(ACT_LOOKUP, '0, 1'b1);                     // kind differs
    push_request(ACT_INSERT, '0, 1'b0);                     // duplicate entry
    push_request(ACT_INSERT, '1, 1'b1);                     // largest hash
    push_request(ACT_LOOKUP, '1, 1'b1);
    push_request(ACT_SPARE, '1, 1'b1);                      // acts as lookup-or-insert
    push_request(ACT_SPARE, 64'h4241, 1'b0);
    push_request(ACT_LOOKUP_OR_INSERT, 64'hFFEE_DDCC_BBAA_0041, 1'b0);
    push_request(ACT_LOOKUP, 64'h41, 1'b0);
    push_request(ACT_LOOKUP, 64'h8000_0000_0000_4100, 1'b0);  // junk after leading NUL
    // These two requests use a name that shares a hash with the earlier two-character one.
    push_request(ACT_LOOKUP_OR_INSERT, 64'h4440, 1'b0);
    push_request(ACT_LOOKUP, 64'h4440, 1'b0);
    push_request(ACT_LOOKUP, 64'h4241, 1'b1);
    push_request(ACT_LOOKUP_OR_INSERT, 64'h4440, 1'b1);
    push_request(ACT_INSERT, 64'h8080_8080_8080_8080, 1'b0);
    push_request(ACT_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F, 1'b1);
    push_request(ACT_INSERT, 64'h4241, 1'b0);
    push_request(ACT_LOOKUP, 64'h4241, 1'b0);
  endtask

  task automatic queue_random(int unsigned count);
    logic [1:0]       act;
    logic [KEY_W-1:0] key;
    logic             kind;
    int unsigned      pick;
    int unsigned      idx;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_INSERT;
      else if (pick < 65) act = ACT_LOOKUP_OR_INSERT;
      else if (pick < 90) act = ACT_LOOKUP;
      else act = ACT_SPARE;
      // Reusing earlier names is what produces hits and kind mismatches.
      if (key_pool.size() > 0 && $urandom_range(99) < 45) begin
        idx = $urandom_range(key_pool.size() - 1);
        key = add_tail(key_pool[idx]);
        kind = kind_pool[idx] ^ ($urandom_range(99) < 15);
      end else begin
        key = add_tail(fresh_name());
        kind = $urandom_range(1);
      end
      push_request(act, key, kind);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (results_seen != requests_queued);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: a new beat is offered only when the line is free or the previous
  // beat was taken at the last rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          action <= pending_requests[0].act;
          key_name <= pending_requests[0].key;
          user_kind <= pending_requests[0].kind;
          in_valid <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each request beat and checks each result beat.
  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    in_fire = rst_ni && in_valid && in_ready;
    if (in_fire) expected_results.push_back(probe_symbol_table(action, key_name, user_kind));
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result beat: status %0d slot %0d entry %0d",
                               status, slot_index, entry_number));
      end else begin
        exp_res = expected_results.pop_front();
        if (status !== exp_res.status || slot_index !== exp_res.slot ||
            entry_number !== exp_res.entry) begin
          note_failure($sformatf({"result %0d: expected status %0d slot %0d entry %0d, ",
                                  "got status %0d slot %0d entry %0d"},
                                 results_seen, exp_res.status, exp_res.slot, exp_res.entry,
                                 status, slot_index, entry_number));
        end
      end
    end
  end

  initial begin
    int fill_left;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    action = ACT_LOOKUP;
    key_name = '0;
    user_kind = 1'b0;
    out_ready = 1'b0;
    in_fire = 1'b0;
    insert_total = 0;
    next_entry_id = 0;
    requests_queued = 0;
    results_seen = 0;
    fail_count = 0;
    send_idle_pct = 32;
    recv_idle_pct = 79;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    queue_random(400);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 32;
    queue_random(400);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(400);
    wait_drained();

    // Fill the table to its capacity, then hit it with requests that need room and with lookups.
    fill_left = int'(TABLE_SLOTS) - 1 - int'(insert_total);
    if (fill_left < 0) fill_left = 0;
    repeat (fill_left) push_request(ACT_INSERT, add_tail(fresh_name()), $urandom_range(1));
    push_request(ACT_INSERT, add_tail(fresh_name()), 1'b0);
    push_request(ACT_LOOKUP_OR_INSERT, add_tail(fresh_name()), 1'b1);
    push_request(ACT_SPARE, add_tail(fresh_name()), 1'b0);
    push_request(ACT_LOOKUP, add_tail(fresh_name()), 1'b1);
    push_request(ACT_LOOKUP_OR_INSERT, key_pool[0], kind_pool[0]);
    push_request(ACT_LOOKUP, key_pool[key_pool.size() / 2], kind_pool[key_pool.size() / 2]);
    wait_drained();

    repeat (100) @(posedge clk_i);
    if (expected_results.size() != 0) note_failure("results still outstanding at end of run");
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
